>>> rtl/tilt_to_led_brightness_core_macros.svh
// assertion macros for the tilt to led brightness core checker
`ifndef TILT_TO_LED_BRIGHTNESS_CORE_MACROS_SVH
`define TILT_TO_LED_BRIGHTNESS_CORE_MACROS_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define TLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define TLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tlb_pkg.sv
// shared types and constants for the tilt to led brightness core
`default_nettype none

package tlb_pkg;

  localparam int LEVEL_W    = 8;
  localparam int QBIT_W     = 3;
  localparam int CFG_DATA_W = 17;
  localparam int ALPHA_W    = 17;
  localparam int ANGLE_W    = 15;
  localparam int AVG_W      = 32;
  localparam int CORDIC_W   = 35;
  localparam int ZACC_W     = 25;
  localparam int TABLE_LEN  = 24;
  localparam int STEP_W     = 5;
  localparam int ARC_W      = 23;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SMOOTHING = 2'd0;
  localparam cfg_idx_t CFG_FULL_OFF  = 2'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 17'd6554;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'd65536;
  localparam logic [ANGLE_W-1:0] FULL_OFF_RESET = 15'd7680;
  localparam logic [ANGLE_W-1:0] DEADBAND_ANGLE = 15'd2048;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'h00;

  localparam logic signed [CORDIC_W-1:0] ONE_G_SCALED = 35'sd1073741824;
  localparam logic signed [ZACC_W-1:0]   ROUND_HALF   = 25'sd128;

  // arctangent of 2^-i in 2^-16 degree
  localparam logic [ARC_W-1:0] ARC_TABLE [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMA,
    ST_CINIT,
    ST_CORDIC,
    ST_ROUND,
    ST_LEVEL,
    ST_DIV,
    ST_DONE
  } tlb_state_e;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } tlb_axis_e;

endpackage

`default_nettype wire

>>> rtl/tilt_to_led_brightness_core.sv
// tilt to led brightness core: ema smoothing, cordic tilt and led fade levels
// each accepted word runs the x axis then the y axis through ema multiply and update,
// cordic init and iterations, rounding and level, and for a tilt in the fade band a divide
// one word at a time, next word taken in the cycle after the result is loaded
// both axes share the cordic add/shift unit and the bit-serial divider
// reset clears control, both averages and sets the registers to their defaults
`default_nettype none

module tilt_to_led_brightness_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int ATAN_STEPS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0]       accel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tlb_pkg::LEVEL_W-1:0]         north_level_o,
  output logic [tlb_pkg::LEVEL_W-1:0]         east_level_o,
  output logic [tlb_pkg::LEVEL_W-1:0]         south_level_o,
  output logic [tlb_pkg::LEVEL_W-1:0]         west_level_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  tlb_pkg::cfg_idx_t                   cfg_index_i,
  input  logic [tlb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import tlb_pkg::*;

  localparam int SCALE_SHIFT = AVG_W - SAMPLE_BITS;
  localparam int PROD_W      = ALPHA_W + 1 + AVG_W + 1;
  localparam int NUM_W       = ANGLE_W + LEVEL_W;
  localparam int SHD_W       = ANGLE_W + LEVEL_W - 1;
  localparam int ABS_W       = ZACC_W - LEVEL_W;

  tlb_state_e state_q, state_d;
  tlb_axis_e  axis_q;
  logic [STEP_W-1:0] step_q;
  logic [QBIT_W-1:0] bit_q;
  logic out_valid_q;

  logic signed [AVG_W-1:0] fx_q, fy_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [ANGLE_W-1:0] full_off_q;

  logic signed [AVG_W-1:0]    sx_q, sy_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [CORDIC_W-1:0] cx_q, cy_q;
  logic signed [ZACC_W-1:0]   cz_q;
  logic [ABS_W-1:0]           a_q;
  logic                       tneg_q;
  logic [NUM_W-1:0]           rem_q;
  logic [LEVEL_W-1:0]         quo_q;
  logic [LEVEL_W-1:0]         north_q, east_q, south_q, west_q;
  logic [LEVEL_W-1:0]         out_north_q, out_east_q, out_south_q, out_west_q;

  logic in_accept, out_load, lvl_wr;
  logic [LEVEL_W-1:0] lvl_val;

  logic [ALPHA_W-1:0]         alpha_eff;
  logic signed [AVG_W-1:0]    cur_s, cur_f, f_new;
  logic signed [AVG_W:0]      diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [CORDIC_W-1:0] f_ext, f_abs, xs, ys;
  logic                       y_pos;
  logic signed [ZACC_W-1:0]   arc, zr;
  logic signed [ABS_W-1:0]    r;
  logic [ABS_W-1:0]           r_abs;
  logic                       r_pos, t_neg;
  logic                       a_in_db, a_past_m;
  logic [ANGLE_W-1:0]         m_minus_a, den;
  logic [NUM_W-1:0]           num;
  logic [SHD_W-1:0]           den_sh;
  logic signed [NUM_W:0]      trial;
  logic                       trial_ok;
  logic [LEVEL_W-1:0]         quo_next;
  logic                       last_step;

  // shared datapath
  always_comb begin
    alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    cur_s     = (axis_q == AXIS_X) ? sx_q : sy_q;
    cur_f     = (axis_q == AXIS_X) ? fx_q : fy_q;
    diff      = {cur_s[AVG_W-1], cur_s} - {cur_f[AVG_W-1], cur_f};
    prod      = $signed({1'b0, alpha_eff}) * diff;
    f_new     = cur_f + prod_q[AVG_W+15:16];
    f_ext     = {{(CORDIC_W-AVG_W){cur_f[AVG_W-1]}}, cur_f};
    f_abs     = f_ext[CORDIC_W-1] ? -f_ext : f_ext;

    xs        = cx_q >>> step_q;
    ys        = cy_q >>> step_q;
    y_pos     = !cy_q[CORDIC_W-1] && (cy_q != '0);
    arc       = $signed({{(ZACC_W-ARC_W){1'b0}}, ARC_TABLE[step_q]});
    last_step = (step_q == STEP_W'(ATAN_STEPS - 1));

    zr        = cz_q + ROUND_HALF;
    r         = zr[ZACC_W-1:LEVEL_W];
    r_abs     = r[ABS_W-1] ? ABS_W'(-r) : ABS_W'(r);
    r_pos     = !r[ABS_W-1] && (r != '0);
    t_neg     = cur_f[AVG_W-1] ? r_pos : r[ABS_W-1];

    a_in_db   = (a_q <= {{(ABS_W-ANGLE_W){1'b0}}, DEADBAND_ANGLE});
    a_past_m  = (a_q >= {{(ABS_W-ANGLE_W){1'b0}}, full_off_q});
    m_minus_a = full_off_q - a_q[ANGLE_W-1:0];
    num       = {m_minus_a, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, m_minus_a};
    den       = full_off_q - DEADBAND_ANGLE;
    den_sh    = {{(SHD_W-ANGLE_W){1'b0}}, den} << bit_q;
    trial     = $signed({1'b0, rem_q}) - $signed({{(NUM_W+1-SHD_W){1'b0}}, den_sh});
    trial_ok  = !trial[NUM_W];
    quo_next  = quo_q | ({{(LEVEL_W-1){1'b0}}, trial_ok} << bit_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_MUL;
      ST_MUL:    state_d = ST_EMA;
      ST_EMA:    state_d = ST_CINIT;
      ST_CINIT:  state_d = ST_CORDIC;
      ST_CORDIC: if (last_step) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_LEVEL;
      ST_LEVEL: begin
        if (a_in_db || a_past_m) begin
          state_d = (axis_q == AXIS_Y) ? ST_DONE : ST_MUL;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_q == '0) state_d = (axis_q == AXIS_Y) ? ST_DONE : ST_MUL;
      end
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_accept  = in_valid_i && (state_q == ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
    lvl_wr     = 1'b0;
    lvl_val    = LEVEL_FULL;
    unique case (state_q)
      ST_LEVEL: begin
        lvl_wr  = a_in_db || a_past_m;
        lvl_val = a_in_db ? LEVEL_FULL : LEVEL_OFF;
      end
      ST_DIV: begin
        lvl_wr  = (bit_q == '0);
        lvl_val = quo_next;
      end
      default: begin
        lvl_wr  = 1'b0;
        lvl_val = LEVEL_FULL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      step_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      fx_q        <= '0;
      fy_q        <= '0;
      alpha_q     <= ALPHA_RESET;
      full_off_q  <= FULL_OFF_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (in_accept) axis_q <= AXIS_X;
      else if (lvl_wr && axis_q == AXIS_X) axis_q <= AXIS_Y;
      if (state_q == ST_CINIT) step_q <= '0;
      else if (state_q == ST_CORDIC) step_q <= step_q + 1'b1;
      if (state_q == ST_LEVEL) bit_q <= QBIT_W'(LEVEL_W - 1);
      else if (state_q == ST_DIV) bit_q <= bit_q - 1'b1;
      if (state_q == ST_EMA) begin
        if (axis_q == AXIS_X) fx_q <= f_new;
        else fy_q <= f_new;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SMOOTHING: alpha_q    <= cfg_data_i[ALPHA_W-1:0];
          CFG_FULL_OFF:  full_off_q <= cfg_data_i[ANGLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sx_q <= $signed({accel_x_i, {SCALE_SHIFT{1'b0}}});
      sy_q <= $signed({accel_y_i, {SCALE_SHIFT{1'b0}}});
    end
    if (state_q == ST_MUL) prod_q <= prod;
    if (state_q == ST_CINIT) begin
      cx_q <= ONE_G_SCALED;
      cy_q <= f_abs;
      cz_q <= '0;
    end else if (state_q == ST_CORDIC) begin
      if (y_pos) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + arc;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - arc;
      end
    end
    if (state_q == ST_ROUND) begin
      a_q    <= r_abs;
      tneg_q <= t_neg;
    end
    if (state_q == ST_LEVEL) begin
      rem_q <= num;
      quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      if (trial_ok) rem_q <= trial[NUM_W-1:0];
      quo_q <= quo_next;
    end
    if (lvl_wr) begin
      if (axis_q == AXIS_X) begin
        east_q <= tneg_q ? lvl_val : LEVEL_FULL;
        west_q <= tneg_q ? LEVEL_FULL : lvl_val;
      end else begin
        north_q <= tneg_q ? lvl_val : LEVEL_FULL;
        south_q <= tneg_q ? LEVEL_FULL : lvl_val;
      end
    end
    if (out_load) begin
      out_north_q <= north_q;
      out_east_q  <= east_q;
      out_south_q <= south_q;
      out_west_q  <= west_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign north_level_o = out_north_q;
  assign east_level_o  = out_east_q;
  assign south_level_o = out_south_q;
  assign west_level_o  = out_west_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

>>> rtl/tlb_checker.sv
// port-level checker for the tilt to led brightness core and its bind
`default_nettype none

`include "tilt_to_led_brightness_core_macros.svh"

module tlb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [tlb_pkg::LEVEL_W-1:0] north_level_o,
  input logic [tlb_pkg::LEVEL_W-1:0] east_level_o,
  input logic [tlb_pkg::LEVEL_W-1:0] south_level_o,
  input logic [tlb_pkg::LEVEL_W-1:0] west_level_o
);

  import tlb_pkg::*;

  logic                 in_take;
  logic                 out_wait;
  logic                 ns_full;
  logic                 ew_full;
  logic [4*LEVEL_W-1:0] levels;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_wait = out_valid_o && out_stall_i;
  assign ns_full  = (north_level_o == LEVEL_FULL) || (south_level_o == LEVEL_FULL);
  assign ew_full  = (east_level_o == LEVEL_FULL) || (west_level_o == LEVEL_FULL);
  assign levels   = {north_level_o, east_level_o, south_level_o, west_level_o};

  // busy right after taking a word
  `TLB_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall_o, "not busy after accept")

  // a new result only comes out of a busy block
  `TLB_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o), "result from idle")

  // opposite leds never both dimmed
  `TLB_ASSERT_NOW(a_opposite_full, out_valid_o, ns_full && ew_full, "opposite leds both dimmed")

  // stalled result word holds
  `TLB_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(levels), "stalled word changed")

endmodule

bind tilt_to_led_brightness_core tlb_checker u_tlb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .north_level_o (north_level_o),
  .east_level_o  (east_level_o),
  .south_level_o (south_level_o),
  .west_level_o  (west_level_o)
);

`default_nettype wire
